/* rtl/core/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and codes of the first-fit segment allocator.
// Holds the command, status and register codes and the cell entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

  localparam int unsigned AddrW = 32;

  localparam logic [AddrW-1:0] RstRegionBase = 32'd0;
  localparam logic [AddrW-1:0] RstRegionSize = 32'd1048576;
  localparam logic [AddrW-1:0] RstMinSplit   = 32'd16;

  typedef enum logic [0:0] {CMD_ALLOC = 1'b0, CMD_FREE = 1'b1} cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FREED     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_REGION_BASE = 2'd0,
    REG_REGION_SIZE = 2'd1,
    REG_MIN_SPLIT   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_MERGE_NEXT, S_MERGE_PREV, S_DONE
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] size;
    logic             used;
  } seg_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD, OP_INIT, OP_ROT, OP_PUT, OP_PUT_INS, OP_DROP
  } op_t;

  typedef struct packed {
    op_t  op;
    seg_t wr;
    seg_t ins;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/ffsa_cell.sv */
// ----------------------------------------------------------------------------
// ffsa_cell: one entry of the segment chain.
// Holds one segment and takes a neighbor's segment on rotate, insert and
// remove commands, or a new value when the command addresses this cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IW  = 4
) (
  input  wire logic                clk,
  input  wire ffsa_pkg::cell_ctl_t ctl,
  input  wire logic [IW-1:0]       pos,
  input  wire ffsa_pkg::seg_t      from_prev,
  input  wire ffsa_pkg::seg_t      from_next,
  output ffsa_pkg::seg_t           seg
);

  localparam int unsigned KW = IW + 1;
  localparam logic [IW:0] Me = KW'(Idx);

  ffsa_pkg::seg_t seg_next;
  logic [IW:0]    k;

  // One extra bit keeps pos + 1 from wrapping at the last cell.
  assign k = {1'b0, pos};

  always_comb begin
    seg_next = seg;
    case (ctl.op)
      ffsa_pkg::OP_INIT: seg_next = (Me == '0) ? ctl.wr : '0;
      ffsa_pkg::OP_ROT:  seg_next = from_next;
      ffsa_pkg::OP_PUT: begin
        if (Me == k) seg_next = ctl.wr;
      end
      ffsa_pkg::OP_PUT_INS: begin
        if (Me == k) seg_next = ctl.wr;
        else if (Me == k + KW'(1)) seg_next = ctl.ins;
        else if (Me > k + KW'(1)) seg_next = from_prev;
      end
      ffsa_pkg::OP_DROP: begin
        if (Me >= k) seg_next = from_next;
      end
      default: seg_next = seg;
    endcase
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
  end

endmodule
`default_nettype wire

/* rtl/core/first_fit_segment_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit: first-fit allocator with coalescing.
// The segment table is a ring of cells that rotates past a head cell.
//
// Channel  Dir  Content
// s_axis   in   tdata: alloc_size[31:0], free_addr[63:32]; tuser: cmd
// m_axis   out  tdata: status[1:0], addr[33:2], zero fill to 40 bits
// cfg      in   index[1:0], data[31:0]
//
// An item is accepted in the idle state. The ring then turns once past the
// head cell, which tests one segment a cycle. The shift state writes the
// found or merged entry and, on a split, inserts the remainder; the states
// S_MERGE_NEXT and S_MERGE_PREV close the gaps of a merge; the done state
// offers the result. s_axis_tready is low from accept until the result
// word is taken, so no new item is accepted before then. Reset is
// synchronous and restores one free segment covering the region; a config
// write to index 0, 1 or 2 does the same and wins over a request in the
// idle state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_unit #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // alloc_size, free_addr
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // status, addr, zero fill
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned N  = MAX_SEGMENTS;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned IW = $clog2(N);

  ffsa_pkg::state_t    state, state_next;
  ffsa_pkg::cell_ctl_t ctl;
  ffsa_pkg::seg_t      segs [N];
  logic [IW-1:0]       pos;

  logic [31:0]       region_base, region_size, min_split;
  logic [CW-1:0]     seg_count;
  logic [IW-1:0]     step, hit_pos;
  logic              hit, do_init, grab_next, drop_prev;
  ffsa_pkg::cmd_t    cmd_q;
  logic [31:0]       req_q, addr_q, res_addr;
  ffsa_pkg::status_t res_status;
  ffsa_pkg::seg_t    hit_seg, prev_seg, next_seg, last_seg;

  // Cell g takes from g+1 on a rotate, so the head cell sees entry t after
  // t rotations; the last cell closes the ring from cell 0.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ffsa_pkg::seg_t fp, fn;
      if (g == 0) begin : g_first
        assign fp = '0;
      end else begin : g_mid
        assign fp = segs[g-1];
      end
      if (g == N - 1) begin : g_last
        assign fn = (ctl.op == ffsa_pkg::OP_ROT) ? segs[0] : '0;
      end else begin : g_notlast
        assign fn = segs[g+1];
      end
      ffsa_cell #(.Idx(g), .IW(IW)) u_cell (
        .clk(clk), .ctl(ctl), .pos(pos), .from_prev(fp), .from_next(fn),
        .seg(segs[g])
      );
    end
  endgenerate

  ffsa_pkg::seg_t cur;
  logic           cur_hit, cur_valid;
  always_comb begin
    cur = segs[0];
    cur_valid = CW'(step) < seg_count;
    if (cmd_q == ffsa_pkg::CMD_ALLOC)
      cur_hit = cur_valid && !cur.used && (cur.size >= req_q);
    else
      cur_hit = cur_valid && (cur.base == addr_q);
  end

  assign cfg_ready     = (state == ffsa_pkg::S_IDLE) && !rst;
  assign s_axis_tready = (state == ffsa_pkg::S_IDLE) && !rst && !cfg_valid;
  assign m_axis_tvalid = (state == ffsa_pkg::S_DONE);
  assign m_axis_tdata  = {6'd0, res_addr, res_status};

  assign do_init = cfg_valid && cfg_ready && (cfg_index <= ffsa_pkg::REG_MIN_SPLIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= ffsa_pkg::RstRegionBase;
      region_size <= ffsa_pkg::RstRegionSize;
      min_split   <= ffsa_pkg::RstMinSplit;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffsa_pkg::REG_REGION_BASE: region_base <= cfg_data;
        ffsa_pkg::REG_REGION_SIZE: region_size <= cfg_data;
        ffsa_pkg::REG_MIN_SPLIT:   min_split   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Init values follow the register file, including the word being written.
  logic [31:0] ib, is_;
  always_comb begin
    ib  = region_base;
    is_ = region_size;
    if (cfg_valid && cfg_ready && cfg_index == ffsa_pkg::REG_REGION_BASE) ib = cfg_data;
    if (cfg_valid && cfg_ready && cfg_index == ffsa_pkg::REG_REGION_SIZE) is_ = cfg_data;
    if (rst) begin
      ib  = ffsa_pkg::RstRegionBase;
      is_ = ffsa_pkg::RstRegionSize;
    end
  end

  // Update terms for the entry found by the scan and its two neighbors.
  logic [31:0] rest, merged_size;
  logic        split, merge_next, merge_prev;
  assign rest        = hit_seg.size - req_q;
  assign split       = (rest >= min_split) && (seg_count < CW'(N));
  assign merge_next  = ((CW'(hit_pos) + CW'(1)) < seg_count) && !next_seg.used;
  assign merge_prev  = (hit_pos != '0) && !prev_seg.used;
  assign merged_size = hit_seg.size + (merge_next ? next_seg.size : 32'd0);

  always_comb begin
    state_next = state;
    ctl.op  = ffsa_pkg::OP_HOLD;
    ctl.wr  = '0;
    ctl.ins = '0;
    pos     = hit_pos;
    case (state)
      ffsa_pkg::S_IDLE: begin
        if (do_init) begin
          ctl.op = ffsa_pkg::OP_INIT;
          ctl.wr.base = ib;
          ctl.wr.size = is_;
        end else if (s_axis_tvalid && s_axis_tready) begin
          state_next = ffsa_pkg::S_SCAN;
        end
      end
      ffsa_pkg::S_SCAN: begin
        ctl.op = ffsa_pkg::OP_ROT;
        if (step == IW'(N - 1)) state_next = ffsa_pkg::S_SHIFT;
      end
      ffsa_pkg::S_SHIFT: begin
        state_next = ffsa_pkg::S_DONE;
        if (hit && cmd_q == ffsa_pkg::CMD_ALLOC) begin
          ctl.op = split ? ffsa_pkg::OP_PUT_INS : ffsa_pkg::OP_PUT;
          ctl.wr.base  = hit_seg.base;
          ctl.wr.size  = split ? req_q : hit_seg.size;
          ctl.wr.used  = 1'b1;
          ctl.ins.base = hit_seg.base + req_q;
          ctl.ins.size = rest;
        end else if (hit) begin
          // A free writes the surviving entry now; the drops follow.
          ctl.op = ffsa_pkg::OP_PUT;
          if (merge_prev) begin
            pos = hit_pos - IW'(1);
            ctl.wr.base = prev_seg.base;
            ctl.wr.size = prev_seg.size + merged_size;
          end else begin
            ctl.wr.base = hit_seg.base;
            ctl.wr.size = merged_size;
          end
          if (merge_next) state_next = ffsa_pkg::S_MERGE_NEXT;
          else if (merge_prev) state_next = ffsa_pkg::S_MERGE_PREV;
        end
      end
      ffsa_pkg::S_MERGE_NEXT: begin
        ctl.op = ffsa_pkg::OP_DROP;
        pos = hit_pos + IW'(1);
        state_next = drop_prev ? ffsa_pkg::S_MERGE_PREV : ffsa_pkg::S_DONE;
      end
      ffsa_pkg::S_MERGE_PREV: begin
        ctl.op = ffsa_pkg::OP_DROP;
        state_next = ffsa_pkg::S_DONE;
      end
      ffsa_pkg::S_DONE: if (m_axis_tready) state_next = ffsa_pkg::S_IDLE;
      default: state_next = ffsa_pkg::S_IDLE;
    endcase
    if (rst) begin
      ctl.op  = ffsa_pkg::OP_INIT;
      ctl.wr  = '0;
      ctl.wr.base = ib;
      ctl.wr.size = is_;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsa_pkg::S_IDLE;
      seg_count <= CW'(1);
      step <= '0; hit <= 1'b0; hit_pos <= '0;
      grab_next <= 1'b0; drop_prev <= 1'b0;
      res_status <= ffsa_pkg::ST_ALLOCATED; res_addr <= '0;
    end else begin
      state <= state_next;
      case (state)
        ffsa_pkg::S_IDLE: begin
          if (do_init) begin
            seg_count <= CW'(1);
          end else if (s_axis_tvalid && s_axis_tready) begin
            cmd_q <= ffsa_pkg::cmd_t'(s_axis_tuser);
            req_q <= s_axis_tdata[31:0];
            addr_q <= s_axis_tdata[63:32];
            step <= '0; hit <= 1'b0; grab_next <= 1'b0;
          end
        end
        ffsa_pkg::S_SCAN: begin
          step <= step + IW'(1);
          last_seg <= cur;
          grab_next <= cur_hit && !hit;
          if (grab_next) next_seg <= cur;
          if (cur_hit && !hit) begin
            hit <= 1'b1;
            hit_pos <= step;
            hit_seg <= cur;
            prev_seg <= last_seg;
          end
        end
        ffsa_pkg::S_SHIFT: begin
          drop_prev <= hit && (cmd_q == ffsa_pkg::CMD_FREE) && merge_prev;
          if (hit && cmd_q == ffsa_pkg::CMD_ALLOC && split) seg_count <= seg_count + CW'(1);
          if (cmd_q == ffsa_pkg::CMD_FREE)
            res_status <= hit ? ffsa_pkg::ST_FREED : ffsa_pkg::ST_NOT_FOUND;
          else
            res_status <= hit ? ffsa_pkg::ST_ALLOCATED : ffsa_pkg::ST_NO_FIT;
          res_addr <= (hit && cmd_q == ffsa_pkg::CMD_ALLOC) ? hit_seg.base : '0;
        end
        ffsa_pkg::S_MERGE_NEXT,
        ffsa_pkg::S_MERGE_PREV: seg_count <= seg_count - CW'(1);
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("ready while result pending");
  a_count: assert property (@(posedge clk) disable iff (rst)
    seg_count != '0) else $error("empty segment table");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(N)) else $error("segment table overflow");
  a_one_accept: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready))
    else $error("request and config accepted together");
`endif

endmodule
`default_nettype wire
